### design/ttgw_pkg.sv
package ttgw_pkg;

  // Field widths of the stream items
  localparam int OP_W       = 1;
  localparam int BYTE_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int CHAR_W     = 7;
  localparam int OROW_W     = 5;
  localparam int OCOL_W     = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [2:0] {
    K_NONE,
    K_CR,
    K_LF,
    K_BS,
    K_PRINT,
    K_READ,
    K_READ_OOR
  } kind_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic addr;
    logic mem;
    logic clr_load;
    logic clr_step;
    logic top_adv;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scroll_req;
    logic  init_last;
    logic  row_last;
    logic  out_free;
  } stat_t;

endpackage

### design/ttgw_ram.sv
module ttgw_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ttgw_ctrl.sv
module ttgw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ttgw_pkg::stat_t stat,
  output ttgw_pkg::cmd_t  cmd
);
  import ttgw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_MEM,
    S_SCROLL,
    S_OUT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_MEM;
      end
      S_MEM: begin
        cmd.mem = 1'b1;
        if (stat.scroll_req) begin
          cmd.clr_load = 1'b1;
          state_next   = S_SCROLL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCROLL: begin
        // blank the old top row, then move the top pointer on
        cmd.clr_step = 1'b1;
        if (stat.row_last) begin
          cmd.top_adv = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  a_read_no_scroll: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEM && (stat.kind == K_READ || stat.kind == K_READ_OOR)) |-> !stat.scroll_req)
    else $error("read item asked for a scroll");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_DECODE && !in_ready))
    else $error("beat accepted but sequencer did not start");

endmodule

### design/ttgw_datapath.sv
module ttgw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ttgw_pkg::cmd_t                cmd,
  output ttgw_pkg::stat_t               stat,
  input  logic                          operation,
  input  logic [ttgw_pkg::BYTE_W-1:0]   data_byte,
  input  logic [ttgw_pkg::RROW_W-1:0]   read_row,
  input  logic [ttgw_pkg::RCOL_W-1:0]   read_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ttgw_pkg::CHAR_W-1:0]   cell_char,
  output logic [ttgw_pkg::OROW_W-1:0]   cursor_row,
  output logic [ttgw_pkg::OCOL_W-1:0]   cursor_col
);
  import ttgw_pkg::*;

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int DEPTH  = ROWS * COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RSUM_W = ((ROW_W > RROW_W) ? ROW_W : RROW_W) + 1;
  localparam int CCMP_W = ((COL_W > RCOL_W) ? COL_W : RCOL_W) + 1;

  // Item held for the duration of its work
  logic              op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [RROW_W-1:0] rrow_q;
  logic [RCOL_W-1:0] rcol_q;

  kind_t             kind_q;
  logic [ROW_W-1:0]  prow_q;
  logic [COL_W-1:0]  pcol_q;
  logic [AW-1:0]     addr_q;

  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  top;
  logic [AW-1:0]     row_base;
  logic [AW-1:0]     clr_addr;

  // Decode signals
  kind_t             kind_d;
  logic [RSUM_W-1:0] row_sel;
  logic [RSUM_W-1:0] row_sum;
  logic [COL_W-1:0]  col_d;
  logic              in_range;

  logic              last_col;
  logic              last_row;
  logic              move_down;
  logic              scroll_req;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;

  always_comb begin
    in_range = (RSUM_W'(rrow_q) < RSUM_W'(ROWS)) && (CCMP_W'(rcol_q) < CCMP_W'(COLS));
    row_sel  = (op_q == OP_READ) ? RSUM_W'(rrow_q) : RSUM_W'(cur_row);
    row_sum  = RSUM_W'(top) + row_sel;
    if (row_sum >= RSUM_W'(ROWS)) begin
      row_sum = row_sum - RSUM_W'(ROWS);
    end

    if (op_q == OP_READ) begin
      kind_d = in_range ? K_READ : K_READ_OOR;
    end else if (byte_q == CH_CR) begin
      kind_d = K_CR;
    end else if (byte_q == CH_LF) begin
      kind_d = K_LF;
    end else if (byte_q == CH_BS) begin
      kind_d = K_BS;
    end else if (byte_q >= PRINT_LO && byte_q <= PRINT_HI) begin
      kind_d = K_PRINT;
    end else begin
      kind_d = K_NONE;
    end

    if (op_q == OP_READ) begin
      col_d = COL_W'(rcol_q);
    end else if (kind_d == K_BS && cur_col != '0) begin
      col_d = cur_col - COL_W'(1);
    end else if (kind_d == K_BS) begin
      col_d = '0;
    end else begin
      col_d = cur_col;
    end
  end

  always_comb begin
    last_col     = (cur_col == COL_W'(COLS - 1));
    last_row     = (cur_row == ROW_W'(ROWS - 1));
    move_down    = (kind_q == K_LF) || (kind_q == K_PRINT && last_col);
    scroll_req   = move_down && last_row;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    unique case (kind_q)
      K_CR: begin
        cur_col_next = '0;
      end
      K_LF: begin
        cur_col_next = '0;
      end
      K_BS: begin
        cur_col_next = pcol_q;
      end
      K_PRINT: begin
        cur_col_next = last_col ? '0 : cur_col + COL_W'(1);
      end
      default: begin
        cur_col_next = cur_col;
      end
    endcase
    if (move_down && !last_row) begin
      cur_row_next = cur_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= operation;
      byte_q <= data_byte;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
    if (cmd.decode) begin
      kind_q <= kind_d;
      prow_q <= row_sum[ROW_W-1:0];
      pcol_q <= col_d;
    end
    if (cmd.addr) begin
      addr_q <= AW'(prow_q) * AW'(COLS) + AW'(pcol_q);
    end
    if (cmd.out_load) begin
      cell_char  <= (kind_q == K_READ) ? ram_rdata : '0;
      cursor_row <= OROW_W'(cur_row);
      cursor_col <= OCOL_W'(cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      row_base  <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.mem) begin
        cur_row <= cur_row_next;
        cur_col <= cur_col_next;
      end
      if (cmd.clr_load) begin
        clr_addr <= row_base;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.top_adv) begin
        if (top == ROW_W'(ROWS - 1)) begin
          top      <= '0;
          row_base <= '0;
        end else begin
          top      <= top + ROW_W'(1);
          row_base <= row_base + AW'(COLS);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = cmd.clr_step || (cmd.mem && (kind_q == K_BS || kind_q == K_PRINT));
    ram_waddr = cmd.clr_step ? clr_addr : addr_q;
    ram_wdata = (!cmd.clr_step && kind_q == K_PRINT) ? byte_q[CHAR_W-1:0] : CH_SPACE;
    ram_re    = cmd.mem && (kind_q == K_READ);
  end

  ttgw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  assign stat.kind       = kind_q;
  assign stat.scroll_req = scroll_req;
  assign stat.init_last  = (clr_addr == AW'(DEPTH - 1));
  assign stat.row_last   = (clr_addr == row_base + AW'(COLS - 1));
  assign stat.out_free   = !out_valid || out_ready;

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < (COL_W + 1)'(COLS)))
    else $error("cursor column past line end");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, top} < (ROW_W + 1)'(ROWS)))
    else $error("top row pointer out of range");

  a_base_tracks_top: assert property (@(posedge clk) disable iff (rst)
    (row_base == AW'(top) * AW'(COLS)))
    else $error("row base out of step with top row pointer");

endmodule

### design/text_terminal_grid_writer_top.sv
// Character grid writer for a simple glass terminal.
//
// Input channel s_axis: one beat per item. tuser selects the operation
// (0 = stream byte, 1 = read cell); tdata carries the stream byte and the
// logical row and column for a read. Output channel m_axis: one beat per
// item, carrying the character read (0 for stream bytes and for reads outside
// the grid) and the cursor position after the item.
//
// Each item walks decode, address, store access and result load; the result
// shows on m_axis in the same cycle that s_axis_tready comes back. A line
// feed or a wrap on the last row scrolls before the result load: the old top
// row is blanked one cell per cycle through the single write port.
//
// After reset the store is swept to spaces, one cell per cycle, and s_axis_tready
// stays low until all ROWS*COLS cells are written. The cursor and top row
// start at zero.
//
// A finished result waits in the output register while the next beat is
// taken; a stalled m_axis holds the next result in its last step only.
module text_terminal_grid_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] data_byte, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [ttgw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] operation
  input  logic [ttgw_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [6:0] cell_char, [11:7] cursor_row, [18:12] cursor_col, [23:19] zero
  output logic [ttgw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import ttgw_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [CHAR_W-1:0] cell_char;
  logic [OROW_W-1:0] cursor_row;
  logic [OCOL_W-1:0] cursor_col;

  ttgw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttgw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (s_axis_tuser[0]),
    .data_byte  (s_axis_tdata[BYTE_W-1:0]),
    .read_row   (s_axis_tdata[BYTE_W +: RROW_W]),
    .read_col   (s_axis_tdata[BYTE_W + RROW_W +: RCOL_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .cell_char  (cell_char),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - CHAR_W - OROW_W - OCOL_W){1'b0}},
                         cursor_col, cursor_row, cell_char};

endmodule

### sim/text_terminal_grid_writer_top_tb.sv
`timescale 1ns / 100ps

module text_terminal_grid_writer_top_tb;
  import ttgw_pkg::*;

  localparam int GRID_ROWS   = 25;
  localparam int GRID_COLS   = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_ITEMS = 450;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic [CHAR_W-1:0] ch;
  } cell_beat_t;

  class screen_tracker;
    logic [CHAR_W-1:0] grid [GRID_ROWS][GRID_COLS];
    logic [OROW_W-1:0] crow;
    logic [OCOL_W-1:0] ccol;
    logic [OROW_W-1:0] top;
    cell_beat_t        awaited [$];
    int n_bytes, n_reads, n_outside, n_scrolls, n_bottom_wraps;
    int n_beats, n_mismatch;

    function new();
      foreach (grid[r, c]) grid[r][c] = CH_SPACE;
      crow = '0;
      ccol = '0;
      top  = '0;
    endfunction

    function int phys(int r);
      return (int'(top) + r) % GRID_ROWS;
    endfunction

    function void step_down();
      if (int'(crow) + 1 >= GRID_ROWS) begin
        // old top line becomes the blank bottom line
        for (int c = 0; c < GRID_COLS; c++) grid[top][c] = CH_SPACE;
        top  = OROW_W'((int'(top) + 1) % GRID_ROWS);
        crow = OROW_W'(GRID_ROWS - 1);
        n_scrolls++;
      end else begin
        crow++;
      end
    endfunction

    function void note_item(logic op, logic [IN_TDATA_W-1:0] d);
      logic [BYTE_W-1:0] b;
      logic [RROW_W-1:0] rr;
      logic [RCOL_W-1:0] rc;
      cell_beat_t        res;
      b  = d[BYTE_W-1:0];
      rr = d[BYTE_W+RROW_W-1:BYTE_W];
      rc = d[BYTE_W+RROW_W+RCOL_W-1:BYTE_W+RROW_W];
      res.ch = '0;
      if (op == OP_STREAM) begin
        n_bytes++;
        if (b == CH_CR) begin
          ccol = '0;
        end else if (b == CH_LF) begin
          ccol = '0;
          step_down();
        end else if (b == CH_BS) begin
          if (ccol > 0) ccol--;
          grid[phys(crow)][ccol] = CH_SPACE;
        end else if (b >= PRINT_LO && b <= PRINT_HI) begin
          grid[phys(crow)][ccol] = b[CHAR_W-1:0];
          if (int'(ccol) + 1 >= GRID_COLS) begin
            ccol = '0;
            if (int'(crow) == GRID_ROWS - 1) n_bottom_wraps++;
            step_down();
          end else begin
            ccol++;
          end
        end
      end else begin
        n_reads++;
        if (rr < GRID_ROWS && rc < GRID_COLS) res.ch = grid[phys(rr)][rc];
        else n_outside++;
      end
      res.row = crow;
      res.col = ccol;
      awaited.push_back(res);
    endfunction

    function void flag(string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("  mismatch: %s", msg);
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] d);
      cell_beat_t got, want;
      got = d[$bits(cell_beat_t)-1:0];
      n_beats++;
      if (awaited.size() == 0) begin
        flag($sformatf("beat %0d with nothing awaited: char %02h row %0d col %0d",
                       n_beats, got.ch, got.row, got.col));
        return;
      end
      want = awaited.pop_front();
      if (got.ch !== want.ch || got.row !== want.row || got.col !== want.col)
        flag($sformatf("beat %0d: char exp %02h got %02h, row exp %0d got %0d, col exp %0d got %0d",
                       n_beats, want.ch, got.ch, want.row, got.row, want.col, got.col));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  screen_tracker board = new();
  bit src_steady;
  bit snk_steady;
  int cycle_count;
  int random_sent;

  text_terminal_grid_writer_top #(
    .COLS(GRID_COLS),
    .ROWS(GRID_ROWS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted items before checking, so a same-edge result finds its entry
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) board.note_item(s_axis_tuser[0], s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, board.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall a drawn number of cycles, then hold ready until a beat lands
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge
  task automatic send_item(logic op, logic [BYTE_W-1:0] b,
                           logic [RROW_W-1:0] rr, logic [RCOL_W-1:0] rc);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W-BYTE_W-RROW_W-RCOL_W){1'b0}}, rc, rr, b};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    send_item(OP_STREAM, b, RROW_W'($urandom), RCOL_W'($urandom));
  endtask

  task automatic read_cell(logic [RROW_W-1:0] rr, logic [RCOL_W-1:0] rc);
    send_item(OP_READ, BYTE_W'($urandom), rr, rc);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    read_cell('0, '0);
    put_byte(PRINT_LO);
    put_byte(PRINT_HI);
    put_byte(8'h00);
    put_byte(8'h7F);
    put_byte(8'hFF);
    put_byte(8'h78);
    put_byte(CH_BS);
    put_byte(CH_BS);
    put_byte(CH_BS);
    // backspace with the column already home
    put_byte(CH_BS);
    put_byte(8'h71);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h6B);
    read_cell('0, '0);
    read_cell(5'd1, '0);
    read_cell(RROW_W'(GRID_ROWS - 1), RCOL_W'(GRID_COLS - 1));
    read_cell(RROW_W'(GRID_ROWS), '0);
    read_cell(5'd31, 7'd127);
    read_cell('0, RCOL_W'(GRID_COLS));
    read_cell('0, 7'd127);
    read_cell(5'd1, 7'd1);
  endtask

  task automatic read_some();
    int n;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        rr = RROW_W'($urandom_range(0, 31));
        rc = RCOL_W'($urandom_range(0, 127));
      end else begin
        rr = $urandom_range(0, 1) ? board.crow : RROW_W'($urandom_range(0, GRID_ROWS - 1));
        rc = RCOL_W'($urandom_range(0, GRID_COLS - 1));
      end
      read_cell(rr, rc);
    end
    random_sent += n;
  endtask

  task automatic run_random();
    int pick, n;
    logic [BYTE_W-1:0] b;
    while (random_sent < RANDOM_ITEMS) begin
      src_steady = ($urandom_range(0, 4) == 0);
      snk_steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // text run; the long ones can wrap
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
        repeat (n) put_byte(BYTE_W'($urandom_range(PRINT_LO, PRINT_HI)));
        random_sent += n;
      end else if (pick < 65) begin
        if ($urandom_range(0, 1)) begin
          put_byte(CH_CR);
          random_sent++;
        end
        n = $urandom_range(1, 5);
        repeat (n) put_byte(CH_LF);
        random_sent += n;
      end else if (pick < 75) begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(CH_BS);
        random_sent += n;
      end else if (pick < 90) begin
        read_some();
      end else begin
        // noise; ignored bytes do not count
        n = $urandom_range(1, 3);
        repeat (n) begin
          b = BYTE_W'($urandom_range(0, 255));
          put_byte(b);
          if ((b >= PRINT_LO && b <= PRINT_HI) || b == CH_CR || b == CH_LF || b == CH_BS)
            random_sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    src_steady    = 1'b0;
    snk_steady    = 1'b0;
    random_sent   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    hold_until_drained();
    run_random();
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d stream bytes and %0d reads (%0d outside the grid) in %0d cycles",
             board.n_bytes, board.n_reads, board.n_outside, cycle_count);
    $display("%0d scrolls, %0d of them from a wrap on the bottom line; %0d mismatches",
             board.n_scrolls, board.n_bottom_wraps, board.n_mismatch);
    if (board.n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### text_terminal_grid_writer_top.f
design/ttgw_pkg.sv
design/ttgw_ram.sv
design/ttgw_ctrl.sv
design/ttgw_datapath.sv
design/text_terminal_grid_writer_top.sv
sim/text_terminal_grid_writer_top_tb.sv
